/* hdl/satd_pkg.sv */
// ============================================================================
// satd_pkg
// Shared widths, types and helper functions for the 4x4 SATD block cost.
// ============================================================================
package satd_pkg;

    localparam int ROW_W   = 32;
    localparam int PIX_W   = 8;
    localparam int NPIX    = 4;
    localparam int DIF_W   = PIX_W + 1;
    localparam int COL_W   = DIF_W + 2;
    localparam int COEF_W  = COL_W + 2;
    localparam int MAG_W   = COEF_W - 2;
    localparam int RSUM_W  = MAG_W + 2;
    localparam int SATD_W  = 15;

    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [SATD_W-1:0]        satd_t;
    typedef logic signed [DIF_W-1:0]  dif_t;
    typedef logic signed [COL_W-1:0]  col_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [RSUM_W-1:0]        rsum_t;

    // Pixel column 0 is the leftmost pixel, held in the top byte of the row.
    function automatic logic [PIX_W-1:0] pixel_at(input row_t row, input logic [1:0] col);
        logic [1:0] slot;
        slot = 2'(NPIX - 1) - col;
        return row[slot*PIX_W +: PIX_W];
    endfunction

    // Magnitude of the coefficient after an arithmetic right shift by one.
    function automatic mag_t half_abs(input coef_t v);
        logic signed [COEF_W-2:0] h;
        h = v[COEF_W-1:1];
        return h[COEF_W-2] ? MAG_W'(-h) : h[MAG_W-1:0];
    endfunction

endpackage

/* hdl/satd_4x4_block_cost_top.sv */
// ============================================================================
// satd_4x4_block_cost_top
// Sum of absolute Hadamard-transformed differences of one 4x4 pixel block.
// ============================================================================
// Usage:
// The input channel carries one request per 4x4 block: four rows of the
// current block and four rows of the candidate block, each row holding four
// 8-bit pixels with the leftmost pixel in the top byte. A request is taken on
// a rising edge where in_valid and in_ready are both high.
// The request is captured in an input register. The differences, the column
// and row Hadamard butterflies, the halving and the absolute-value sum are
// then formed in one combinational pass into the result register.
// The result register loads the result once it is empty or being read, and
// satd_value and out_valid are driven from it; one request can be taken
// every cycle while the receiver does not stall the output.
// When the receiver holds out_ready low, the result register keeps its value
// and the input register still takes one more request; in_ready drops only
// when both registers are full.
// Reset clears both valid flags; no result is pending after reset.
// ============================================================================
module satd_4x4_block_cost_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  satd_pkg::row_t       cur_row0,
    input  satd_pkg::row_t       cur_row1,
    input  satd_pkg::row_t       cur_row2,
    input  satd_pkg::row_t       cur_row3,
    input  satd_pkg::row_t       cand_row0,
    input  satd_pkg::row_t       cand_row1,
    input  satd_pkg::row_t       cand_row2,
    input  satd_pkg::row_t       cand_row3,
    output logic                 out_valid,
    input  logic                 out_ready,
    output satd_pkg::satd_t      satd_value
);
    import satd_pkg::*;

    logic  s1_valid_reg;
    logic  s1_valid_next;
    row_t  cur_reg  [NPIX];
    row_t  cand_reg [NPIX];
    logic  out_valid_reg;
    logic  out_valid_next;
    satd_t satd_reg;
    satd_t satd_next;
    logic  s2_ready;
    logic  s1_load;

    dif_t  dif  [NPIX][NPIX];
    col_t  colt [NPIX][NPIX];
    coef_t coef [NPIX][NPIX];
    mag_t  mag  [NPIX][NPIX];
    rsum_t rsum [NPIX];

    assign s2_ready  = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s2_ready;
    assign s1_load   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign satd_value = satd_reg;

    always_comb
    begin
        s1_valid_next  = s1_load || (s1_valid_reg && !s2_ready);
        out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            cur_reg[0]  <= cur_row0;
            cur_reg[1]  <= cur_row1;
            cur_reg[2]  <= cur_row2;
            cur_reg[3]  <= cur_row3;
            cand_reg[0] <= cand_row0;
            cand_reg[1] <= cand_row1;
            cand_reg[2] <= cand_row2;
            cand_reg[3] <= cand_row3;
        end
        if (s2_ready && s1_valid_reg)
        begin
            satd_reg <= satd_next;
        end
    end

    always_comb
    begin
        for (int r = 0; r < NPIX; r++)
        begin
            for (int c = 0; c < NPIX; c++)
            begin
                dif[r][c] = DIF_W'($signed({1'b0, pixel_at(cur_reg[r], 2'(c))}))
                          - DIF_W'($signed({1'b0, pixel_at(cand_reg[r], 2'(c))}));
            end
        end

        for (int c = 0; c < NPIX; c++)
        begin
            colt[0][c] = (COL_W'(dif[0][c]) + COL_W'(dif[3][c]))
                       + (COL_W'(dif[1][c]) + COL_W'(dif[2][c]));
            colt[1][c] = (COL_W'(dif[0][c]) - COL_W'(dif[3][c]))
                       + (COL_W'(dif[1][c]) - COL_W'(dif[2][c]));
            colt[2][c] = (COL_W'(dif[0][c]) + COL_W'(dif[3][c]))
                       - (COL_W'(dif[1][c]) + COL_W'(dif[2][c]));
            colt[3][c] = (COL_W'(dif[0][c]) - COL_W'(dif[3][c]))
                       - (COL_W'(dif[1][c]) - COL_W'(dif[2][c]));
        end

        for (int k = 0; k < NPIX; k++)
        begin
            coef[k][0] = (COEF_W'(colt[k][0]) + COEF_W'(colt[k][3]))
                       + (COEF_W'(colt[k][1]) + COEF_W'(colt[k][2]));
            coef[k][1] = (COEF_W'(colt[k][0]) - COEF_W'(colt[k][3]))
                       + (COEF_W'(colt[k][1]) - COEF_W'(colt[k][2]));
            coef[k][2] = (COEF_W'(colt[k][0]) + COEF_W'(colt[k][3]))
                       - (COEF_W'(colt[k][1]) + COEF_W'(colt[k][2]));
            coef[k][3] = (COEF_W'(colt[k][0]) - COEF_W'(colt[k][3]))
                       - (COEF_W'(colt[k][1]) - COEF_W'(colt[k][2]));
            for (int c = 0; c < NPIX; c++)
            begin
                mag[k][c] = half_abs(coef[k][c]);
            end
            rsum[k] = (RSUM_W'(mag[k][0]) + RSUM_W'(mag[k][1]))
                    + (RSUM_W'(mag[k][2]) + RSUM_W'(mag[k][3]));
        end

        satd_next = (SATD_W'(rsum[0]) + SATD_W'(rsum[1]))
                  + (SATD_W'(rsum[2]) + SATD_W'(rsum[3]));
    end

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted request did not reach the input register");

    a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> out_valid)
        else $error("input register content did not reach the result register");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid && !out_ready) |-> !in_ready)
        else $error("request taken while both registers are full");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (satd_value <= SATD_W'(32640)))
        else $error("block cost out of range");
`endif

endmodule

/* dv/tb_satd_4x4_block_cost_top.sv */
// ============================================================================
// tb_satd_4x4_block_cost_top
// Self-checking testbench for the 4x4 SATD block cost.
// A directed set of blocks covers the extreme and sign-sensitive cases. About
// 1400 random block pairs follow, with random idle bursts on both channels and
// one long receiver stall that backs up the pipeline. Every result is compared
// in order against an independent prediction of the transform.
// ============================================================================
module tb_satd_4x4_block_cost_top;

    import satd_pkg::*;

    localparam int NUM_RANDOM  = 1400;
    localparam int QUIET_TAIL  = 200;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AFTER  = 300;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        row_t [3:0] cur;
        row_t [3:0] cand;
    } block_pair_t;

    class satd_checker;
        satd_t expected_costs[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        static function void hadamard4(input int x0, input int x1, input int x2,
                                       input int x3, output int y[4]);
            int s03;
            int d03;
            int s12;
            int d12;
            s03 = x0 + x3;
            d03 = x0 - x3;
            s12 = x1 + x2;
            d12 = x1 - x2;
            y[0] = s03 + s12;
            y[1] = d03 + d12;
            y[2] = s03 - s12;
            y[3] = d03 - d12;
        endfunction

        static function satd_t block_satd(input block_pair_t b);
            int diff[4][4];
            int colt[4][4];
            int y[4];
            int h;
            int total;
            total = 0;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    diff[r][c] = int'(b.cur[r][31 - 8 * c -: 8]) -
                                 int'(b.cand[r][31 - 8 * c -: 8]);
                end
            end
            for (int c = 0; c < 4; c++)
            begin
                hadamard4(diff[0][c], diff[1][c], diff[2][c], diff[3][c], y);
                for (int k = 0; k < 4; k++)
                begin
                    colt[k][c] = y[k];
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                hadamard4(colt[k][0], colt[k][1], colt[k][2], colt[k][3], y);
                for (int c = 0; c < 4; c++)
                begin
                    h = y[c] >>> 1;
                    total += (h < 0) ? -h : h;
                end
            end
            return satd_t'(total);
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        function void note_request(input block_pair_t b);
            expected_costs.push_back(block_satd(b));
        endfunction

        task check_result(input satd_t got);
            satd_t want;
            if (expected_costs.size() == 0)
            begin
                report_mismatch($sformatf("satd_value %0d with no request outstanding", got));
            end
            else
            begin
                want = expected_costs.pop_front();
                if (got !== want)
                begin
                    report_mismatch($sformatf("satd_value got %0d expected %0d", got, want));
                end
            end
        endtask

        function int pending();
            return expected_costs.size();
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    row_t  cur_row0;
    row_t  cur_row1;
    row_t  cur_row2;
    row_t  cur_row3;
    row_t  cand_row0;
    row_t  cand_row1;
    row_t  cand_row2;
    row_t  cand_row3;
    logic  out_valid;
    logic  out_ready;
    satd_t satd_value;

    logic  long_hold;
    logic  no_idle;
    int    sent_count;

    satd_checker sb;

    satd_4x4_block_cost_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cur_row0   (cur_row0),
        .cur_row1   (cur_row1),
        .cur_row2   (cur_row2),
        .cur_row3   (cur_row3),
        .cand_row0  (cand_row0),
        .cand_row1  (cand_row1),
        .cand_row2  (cand_row2),
        .cand_row3  (cand_row3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .satd_value (satd_value)
    );

    always #5 clk = ~clk;

    function automatic block_pair_t make_pair(input row_t c0, input row_t c1,
                                              input row_t c2, input row_t c3,
                                              input row_t k0, input row_t k1,
                                              input row_t k2, input row_t k3);
        block_pair_t b;
        b.cur[0]  = c0;
        b.cur[1]  = c1;
        b.cur[2]  = c2;
        b.cur[3]  = c3;
        b.cand[0] = k0;
        b.cand[1] = k1;
        b.cand[2] = k2;
        b.cand[3] = k3;
        return b;
    endfunction

    function automatic block_pair_t random_pair();
        block_pair_t b;
        int          mode;
        logic [7:0]  px;
        mode = $urandom_range(0, 5);
        for (int r = 0; r < 4; r++)
        begin
            b.cur[r]  = $urandom;
            b.cand[r] = $urandom;
            for (int c = 0; c < 4; c++)
            begin
                case (mode)
                    1: b.cand[r][31 - 8 * c -: 8] = b.cur[r][31 - 8 * c -: 8];
                    2:
                    begin
                        px = b.cur[r][31 - 8 * c -: 8] + 8'($urandom_range(0, 6)) - 8'd3;
                        b.cand[r][31 - 8 * c -: 8] = px;
                    end
                    3:
                    begin
                        b.cur[r][31 - 8 * c -: 8]  = {8{1'($urandom)}};
                        b.cand[r][31 - 8 * c -: 8] = {8{1'($urandom)}};
                    end
                    4: b.cand[r][31 - 8 * c -: 8] = {8{1'($urandom)}};
                    default: ;
                endcase
            end
        end
        return b;
    endfunction

    task send_request(input block_pair_t b, input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cur_row0  <= b.cur[0];
        cur_row1  <= b.cur[1];
        cur_row2  <= b.cur[2];
        cur_row3  <= b.cur[3];
        cand_row0 <= b.cand[0];
        cand_row1 <= b.cand[1];
        cand_row2 <= b.cand[2];
        cand_row3 <= b.cand[3];
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_request(b);
        sent_count++;
    endtask

    initial
    begin : timeout
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : hold_off
        long_hold <= 1'b0;
        wait (sent_count >= HOLD_AFTER);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                sb.check_result(satd_value);
            end
            if (long_hold)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : request_side
        block_pair_t directed[$];
        row_t        r0;
        row_t        r1;
        sb         = new();
        sent_count = 0;
        rst_n     <= 1'b0;
        no_idle   <= 1'b0;
        in_valid  <= 1'b0;
        cur_row0  <= '0;
        cur_row1  <= '0;
        cur_row2  <= '0;
        cur_row3  <= '0;
        cand_row0 <= '0;
        cand_row1 <= '0;
        cand_row2 <= '0;
        cand_row3 <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, the negative DC term, floor halving of negative values,
        // and single-basis patterns along columns, rows and both.
        directed.push_back(make_pair('0, '0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_pair('1, '1, '1, '1, '0, '0, '0, '0));
        directed.push_back(make_pair('0, '0, '0, '0, '1, '1, '1, '1));
        directed.push_back(make_pair('1, '1, '1, '1, '1, '1, '1, '1));
        directed.push_back(make_pair(32'hFF00FF00, 32'hFF00FF00, 32'hFF00FF00, 32'hFF00FF00,
                                     32'h00FF00FF, 32'h00FF00FF, 32'h00FF00FF, 32'h00FF00FF));
        directed.push_back(make_pair(32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000,
                                     32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF));
        directed.push_back(make_pair(32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF,
                                     32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00));
        directed.push_back(make_pair(32'hFFFF0000, 32'hFFFF0000, 32'h0000FFFF, 32'h0000FFFF,
                                     '0, '0, '0, '0));
        directed.push_back(make_pair(32'h01000000, '0, '0, '0, '0, '0, '0, '0));
        directed.push_back(make_pair('0, '0, '0, '0, 32'h01000000, '0, '0, '0));
        directed.push_back(make_pair('0, '0, '0, 32'h00000003, '0, '0, '0, '0));
        directed.push_back(make_pair('0, '0, '0, '0, '0, '0, '0, 32'h00000003));
        directed.push_back(make_pair(32'h80808080, 32'h80808080, 32'h80808080, 32'h80808080,
                                     32'h7F7F7F7F, 32'h7F7F7F7F, 32'h7F7F7F7F, 32'h7F7F7F7F));
        directed.push_back(make_pair(32'h7F7F7F7F, 32'h7F7F7F7F, 32'h7F7F7F7F, 32'h7F7F7F7F,
                                     32'h80808080, 32'h80808080, 32'h80808080, 32'h80808080));
        directed.push_back(make_pair(32'hFF000000, '0, '0, '0, 32'h000000FF, '0, '0, '0));
        directed.push_back(make_pair(32'h0000FF00, 32'h00FF0000, '0, '0, '0, '0, 32'hFF000000,
                                     32'h000000FF));
        r0 = $urandom;
        r1 = $urandom;
        directed.push_back(make_pair(r0, r1, r1, r0, r0, r1, r1, r0));
        directed.push_back(make_pair($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom));
        foreach (directed[i])
        begin
            send_request(directed[i], 1'b0);
        end

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM - QUIET_TAIL)
            begin
                no_idle <= 1'b1;
            end
            send_request(random_pair(), i < NUM_RANDOM - QUIET_TAIL);
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/satd_pkg.sv
hdl/satd_4x4_block_cost_top.sv
dv/tb_satd_4x4_block_cost_top.sv
